// File: design/nnue_accumulator_engine_top_defines.svh
// ----------------------------------------------------------------------------
// nnue_accumulator_engine_top_defines.svh
// Assertion macros shared by the checker of the accumulator engine.
// ----------------------------------------------------------------------------
`ifndef NNUE_ACCUMULATOR_ENGINE_TOP_DEFINES_SVH
`define NNUE_ACCUMULATOR_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NAE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nae_checker: same-cycle property violated");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NAE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nae_checker: next-cycle property violated");

`endif

// File: design/nae_pkg.sv
// ----------------------------------------------------------------------------
// nae_pkg
// Shared types and constants of the accumulator engine.
// ----------------------------------------------------------------------------
package nae_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [2:0] {
        ACT_WRITE_WEIGHT  = 3'd0,
        ACT_WRITE_BIAS    = 3'd1,
        ACT_REFRESH_BEGIN = 3'd2,
        ACT_REFRESH_ADD   = 3'd3,
        ACT_UPDATE_REMOVE = 3'd4,
        ACT_UPDATE_ADD    = 3'd5,
        ACT_APPLY_DELTA   = 3'd6,
        ACT_READ          = 3'd7
    } t_action;

    // Lanes handled by one weight word and one lane group.
    localparam int LANES_PER_GROUP = 8;

    // Field widths.
    localparam int FEATURE_W = 10;
    localparam int WORD_IDX_W = 3;
    localparam int WEIGHT_WORD_W = 64;
    localparam int BIAS_LANE_W = 6;
    localparam int VALUE_W = 32;
    localparam int DELTA_W = 16;
    localparam int LANE_IDX_W = 6;

    // Packed bus widths, padded to whole bytes.
    localparam int IN_TDATA_W = 120;
    localparam int OUT_TDATA_W = 40;

    // Weight-bank request issued when a beat is accepted.
    typedef struct packed {
        logic                     rd_en;
        logic                     wr_en;
        logic [WORD_IDX_W-1:0]    word_index;
        logic [WEIGHT_WORD_W-1:0] weight_word;
    } t_mem_req;

    // Lane operation issued in the cycle after the accepted beat, with the weight row at hand.
    typedef struct packed {
        logic                   valid;
        t_action                action;
        logic                   feat_ok;
        logic [BIAS_LANE_W-1:0] bias_lane;
        logic [VALUE_W-1:0]     bias_value;
    } t_op_ctrl;

endpackage

// File: design/nae_lane_group.sv
// ----------------------------------------------------------------------------
// nae_lane_group
// One group of eight accumulator lanes with its own weight bank, biases,
// accumulators and deltas.
// ----------------------------------------------------------------------------
module nae_lane_group
    import nae_pkg::*;
#(
    parameter int NUM_FEATURES = 1024,
    parameter int FEAT_W       = 10,
    parameter int GROUP_IDX    = 0
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_mem_req                                i_mem_req,
    input  logic [FEAT_W-1:0]                       i_addr,
    input  t_op_ctrl                                i_op,
    output logic [LANES_PER_GROUP-1:0][VALUE_W-1:0] o_acc
);

    // Weight bank: one 64-bit word of this group per feature.
    logic [WEIGHT_WORD_W-1:0] r_mem [NUM_FEATURES];
    logic [WEIGHT_WORD_W-1:0] r_rd_word;
    logic                     w_wr_hit;
    logic                     w_bias_hit;

    assign w_wr_hit = i_mem_req.wr_en &&
                      (i_mem_req.word_index == WORD_IDX_W'(GROUP_IDX));
    assign w_bias_hit = i_op.valid && (i_op.action == ACT_WRITE_BIAS) &&
                        (i_op.bias_lane[BIAS_LANE_W-1:3] == 3'(GROUP_IDX));

    // Bank write and registered row read.
    always_ff @(posedge i_clk) begin
        if (w_wr_hit) begin
            r_mem[i_addr] <= i_mem_req.weight_word;
        end
        if (i_mem_req.rd_en) begin
            r_rd_word <= r_mem[i_addr];
        end
    end

    // One lane core per weight byte.
    for (genvar l = 0; l < LANES_PER_GROUP; l++) begin : g_lane
        logic [7:0]         w_weight;
        logic [VALUE_W-1:0] r_bias;
        logic [VALUE_W-1:0] r_acc;
        logic [VALUE_W-1:0] n_acc;
        logic [DELTA_W-1:0] r_delta;
        logic [DELTA_W-1:0] n_delta;

        assign w_weight = r_rd_word[8*l +: 8];

        // Bias entry, left undefined until written.
        always_ff @(posedge i_clk) begin
            if (w_bias_hit && (i_op.bias_lane[2:0] == 3'(l))) begin
                r_bias <= i_op.bias_value;
            end
        end

        // Lane arithmetic, all wrapping.
        always_comb begin
            n_acc   = r_acc;
            n_delta = r_delta;
            if (i_op.valid) begin
                case (i_op.action)
                    ACT_REFRESH_BEGIN: begin
                        n_acc = r_bias;
                    end
                    ACT_REFRESH_ADD: begin
                        if (i_op.feat_ok) begin
                            n_acc = r_acc + {{(VALUE_W-8){w_weight[7]}}, w_weight};
                        end
                    end
                    ACT_UPDATE_REMOVE: begin
                        if (i_op.feat_ok) begin
                            n_delta = r_delta - {{(DELTA_W-8){w_weight[7]}}, w_weight};
                        end
                    end
                    ACT_UPDATE_ADD: begin
                        if (i_op.feat_ok) begin
                            n_delta = r_delta + {{(DELTA_W-8){w_weight[7]}}, w_weight};
                        end
                    end
                    ACT_APPLY_DELTA: begin
                        n_acc   = r_acc + {{(VALUE_W-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
                        n_delta = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc   <= '0;
                r_delta <= '0;
            end else begin
                r_acc   <= n_acc;
                r_delta <= n_delta;
            end
        end

        assign o_acc[l] = r_acc;
    end

endmodule

// File: design/nae_readout.sv
// ----------------------------------------------------------------------------
// nae_readout
// Merging stage: walks the lanes of all groups and streams one lane a beat
// through a registered output stage.
// ----------------------------------------------------------------------------
module nae_readout
    import nae_pkg::*;
#(
    parameter int ACC_LEN = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ACC_LEN-1:0][VALUE_W-1:0] i_lanes,
    input  logic                            i_m_tready,
    output logic                            o_busy,
    output logic                            o_valid,
    output logic [LANE_IDX_W-1:0]           o_lane_index,
    output logic [VALUE_W-1:0]              o_lane_value,
    output logic                            o_last
);

    localparam int LANE_W = $clog2(ACC_LEN);

    logic              r_busy;
    logic [LANE_W-1:0] r_lane;
    logic              r_valid;
    logic [LANE_IDX_W-1:0] r_index;
    logic [VALUE_W-1:0]    r_value;
    logic              r_last;
    logic              w_load;
    logic              w_at_end;

    // A lane moves into the output stage whenever that stage is free or drains.
    assign w_load   = r_busy && (!r_valid || i_m_tready);
    assign w_at_end = (r_lane == LANE_W'(ACC_LEN - 1));

    // Lane walk and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_lane  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_lane <= '0;
            end else if (w_load) begin
                if (w_at_end) begin
                    r_busy <= 1'b0;
                end
                r_lane <= r_lane + LANE_W'(1);
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_index <= LANE_IDX_W'(r_lane);
            r_value <= i_lanes[r_lane];
            r_last  <= w_at_end;
        end
    end

    assign o_busy       = r_busy;
    assign o_valid      = r_valid;
    assign o_lane_index = r_index;
    assign o_lane_value = r_value;
    assign o_last       = r_last;

endmodule

// File: design/nnue_accumulator_engine_top.sv
// ----------------------------------------------------------------------------
// nnue_accumulator_engine_top
// First-layer accumulator with int8 weight rows, int32 biases, incremental
// 16-bit deltas and a streamed lane readout.
// ----------------------------------------------------------------------------
// Weight writes, bias writes, refresh begin/add, update remove/add and apply
// each take one input beat, and a new one is accepted every cycle while no
// read holds the input off: the feature row is read from ACC_LEN/8 parallel
// 64-bit weight banks at the edge that accepts the beat, and all lanes update
// together in the following cycle. A read holds the input off while the lanes
// leave one per output beat through the single-lane output stage. ACC_LEN
// must be a multiple of eight. Weight and bias entries hold no reset value
// and must be written before a refresh or update uses them; there is no
// clearing pass. Input tuser carries the action; output tlast marks the
// final lane.
// ----------------------------------------------------------------------------
module nnue_accumulator_engine_top
    import nae_pkg::*;
#(
    parameter int ACC_LEN      = 32,
    parameter int NUM_FEATURES = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata, from bit 0: feature_index[9:0], word_index[12:10],
    // weight_word[76:13], bias_lane[82:77], bias_value[114:83], zero pad.
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: action[2:0].
    input  logic [2:0]             i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata, from bit 0: lane_index[5:0], lane_value[37:6], zero pad.
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int NUM_GROUPS = ACC_LEN / LANES_PER_GROUP;
    localparam int FEAT_W     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    // Input field unpacking.
    logic [FEATURE_W-1:0]     w_feature;
    logic [WORD_IDX_W-1:0]    w_word_index;
    logic [WEIGHT_WORD_W-1:0] w_weight_word;
    logic [BIAS_LANE_W-1:0]   w_bias_lane;
    logic [VALUE_W-1:0]       w_bias_value;
    t_action                  w_action;
    logic [31:0]              w_feat_ext;
    logic                     w_feat_ok;
    logic                     w_accept;

    assign w_feature     = i_s_tdata[9:0];
    assign w_word_index  = i_s_tdata[12:10];
    assign w_weight_word = i_s_tdata[76:13];
    assign w_bias_lane   = i_s_tdata[82:77];
    assign w_bias_value  = i_s_tdata[114:83];
    assign w_action      = t_action'(i_s_tuser);
    assign w_feat_ext    = {{(32-FEATURE_W){1'b0}}, w_feature};
    assign w_feat_ok     = (w_feat_ext < 32'(NUM_FEATURES));
    assign w_accept      = i_s_tvalid && o_s_tready;

    // Bank request at the accepted beat.
    t_mem_req          w_mem_req;
    logic [FEAT_W-1:0] w_addr;

    assign w_addr                = w_feat_ext[FEAT_W-1:0];
    assign w_mem_req.rd_en       = w_accept;
    assign w_mem_req.wr_en       = w_accept && (w_action == ACT_WRITE_WEIGHT) && w_feat_ok;
    assign w_mem_req.word_index  = w_word_index;
    assign w_mem_req.weight_word = w_weight_word;

    // Operation stage, aligned with the registered bank read.
    logic                   r_s1_valid;
    t_action                r_s1_action;
    logic                   r_s1_feat_ok;
    logic [BIAS_LANE_W-1:0] r_s1_bias_lane;
    logic [VALUE_W-1:0]     r_s1_bias_value;
    t_op_ctrl               w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_action     <= w_action;
            r_s1_feat_ok    <= w_feat_ok;
            r_s1_bias_lane  <= w_bias_lane;
            r_s1_bias_value <= w_bias_value;
        end
    end

    assign w_op.valid      = r_s1_valid;
    assign w_op.action     = r_s1_action;
    assign w_op.feat_ok    = r_s1_feat_ok;
    assign w_op.bias_lane  = r_s1_bias_lane;
    assign w_op.bias_value = r_s1_bias_value;

    // Lane groups, one per weight word of a row.
    logic [ACC_LEN-1:0][VALUE_W-1:0] w_lanes;

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
        nae_lane_group #(
            .NUM_FEATURES (NUM_FEATURES),
            .FEAT_W       (FEAT_W),
            .GROUP_IDX    (g)
        ) u_group (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_mem_req (w_mem_req),
            .i_addr    (w_addr),
            .i_op      (w_op),
            .o_acc     (w_lanes[g*LANES_PER_GROUP +: LANES_PER_GROUP])
        );
    end

    // Readout of all lanes.
    logic                  w_start;
    logic                  w_busy;
    logic [LANE_IDX_W-1:0] w_lane_index;
    logic [VALUE_W-1:0]    w_lane_value;

    assign w_start = r_s1_valid && (r_s1_action == ACT_READ);

    nae_readout #(
        .ACC_LEN (ACC_LEN)
    ) u_readout (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_lanes      (w_lanes),
        .i_m_tready   (i_m_tready),
        .o_busy       (w_busy),
        .o_valid      (o_m_tvalid),
        .o_lane_index (w_lane_index),
        .o_lane_value (w_lane_value),
        .o_last       (o_m_tlast)
    );

    // Lanes stay frozen from the read beat until the last lane is captured.
    assign o_s_tready = !w_busy && !w_start;
    assign o_m_tdata  = {{(OUT_TDATA_W-LANE_IDX_W-VALUE_W){1'b0}}, w_lane_value, w_lane_index};

endmodule

// File: design/nae_checker.sv
// ----------------------------------------------------------------------------
// nae_checker
// Port-level checks of the accumulator engine readout, bound to the top.
// ----------------------------------------------------------------------------
`include "nnue_accumulator_engine_top_defines.svh"

module nae_checker #(
    parameter int ACC_LEN = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [39:0]  o_m_tdata,
    input logic         o_m_tlast
);

    // Output beat moves, output beat waits, and the lane it carries.
    logic       w_out_beat;
    logic       w_out_stall;
    logic [5:0] w_lane;

    assign w_out_beat  = o_m_tvalid && i_m_tready;
    assign w_out_stall = o_m_tvalid && !i_m_tready;
    assign w_lane      = o_m_tdata[5:0];

    // A stalled output beat keeps its payload.
    `NAE_ASSERT_NXT(a_out_hold, w_out_stall, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // The last beat of a read carries the highest lane.
    `NAE_ASSERT_IMP(a_last_lane, o_m_tvalid && o_m_tlast, w_lane == 6'(ACC_LEN - 1))

    // Lanes follow each other without gaps and in increasing order.
    `NAE_ASSERT_NXT(a_lane_step, w_out_beat && !o_m_tlast, o_m_tvalid && (w_lane == $past(w_lane) + 6'd1))

    // No input beat is taken while a beat other than the last of a read is on the output.
    `NAE_ASSERT_IMP(a_in_hold, o_m_tvalid && !o_m_tlast, !o_s_tready)

endmodule

bind nnue_accumulator_engine_top nae_checker #(
    .ACC_LEN (ACC_LEN)
) u_nae_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
